### hw/rtl/adm_pkg.sv
// adm_pkg: shared constants, codes and the arctangent table of the anchor drift monitor
// no dependencies; imported by adm_bearing and anchor_drift_monitor_top
package adm_pkg;

    localparam int OFF_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ARMED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_LAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_LON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_COS    = 3'd5;

    // status codes
    localparam logic [1:0] STATUS_NOT_ARMED = 2'd0;
    localparam logic [1:0] STATUS_NO_FIX    = 2'd1;
    localparam logic [1:0] STATUS_DRAGGING  = 2'd2;
    localparam logic [1:0] STATUS_NO_MSG    = 2'd3;

    // scaling of 1e-7 degree to 1/16 m
    // both axes divide by 15625, east after dropping its low 16 bits
    localparam logic [16:0] DEG_TO_SIXTEENTH = 17'd2778;
    localparam logic [29:0] NORTH_DEN  = 30'd15625;
    localparam logic [61:0] NORTH_HALF = 62'd7812;
    localparam logic [61:0] EAST_HALF  = 62'd512000000;
    localparam logic [31:0] OFF_POS_MAX = 32'd8388607;
    localparam logic [31:0] OFF_NEG_MAX = 32'd8388608;

    // floor(2^30 / 15625): quotient estimate low by at most one
    localparam logic [16:0] DIV_RECIP = 17'd68719;

    // cordic angles in Q16 degrees
    localparam int CORDIC_STEPS = 18;
    localparam logic signed [26:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [26:0] DEG360_Q16 = 27'sd23592960;
    localparam logic signed [26:0] HALF_DEG_Q16 = 27'sd32768;

    function automatic logic [22:0] adm_atan(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/anchor_drift_monitor_top.sv
// anchor_drift_monitor_top: offset, distance, bearing, drag alarm and track sampling
// depends on adm_pkg and adm_bearing
//
//  port group    | direction | handshake               | content
//  config        | in        | i_cfg_wr_en             | i_cfg_index, i_cfg_data
//  fix word      | in        | i_in_valid / o_in_stall | latitude, longitude, present, age, time
//  result word   | out       | o_out_valid/i_out_stall | offsets, distance, bearing, flags
//
// one fix word is worked on at a time, from acceptance until its result is registered: one shared
// multiplier scales each axis and runs a three-digit reciprocal divide, then a 24-step
// square root and an 18-step cordic unit follow; the result then goes to the output register
// o_in_stall is high from acceptance until the result sits in the output register
// a finished result waits in the output register; the next word is taken meanwhile
// reset is synchronous, active low; the user must write configuration only while idle (not enforced)
module anchor_drift_monitor_top #(
    parameter int SAMPLE_INTERVAL_MS = 3000,
    parameter int FIX_TIMEOUT_MS     = 10000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [adm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [adm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [30:0]                  i_fix_latitude,
    input  logic signed [31:0]                  i_fix_longitude,
    input  logic                                i_fix_present,
    input  logic [15:0]                         i_fix_age_ms,
    input  logic [31:0]                         i_time_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [adm_pkg::OFF_W-1:0]    o_north_offset,
    output logic signed [adm_pkg::OFF_W-1:0]    o_east_offset,
    output logic [adm_pkg::OFF_W-1:0]           o_distance,
    output logic [8:0]                          o_bearing_deg,
    output logic                                o_position_valid,
    output logic                                o_drag_alarm,
    output logic [1:0]                          o_status,
    output logic                                o_track_sampled,
    output logic [adm_pkg::OFF_W-1:0]           o_max_drift
);
    import adm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_MULN   = 13'b0_0000_0000_0010,
        S_MULE1  = 13'b0_0000_0000_0100,
        S_MULE2  = 13'b0_0000_0000_1000,
        S_DIVSET = 13'b0_0000_0001_0000,
        S_DIVQ   = 13'b0_0000_0010_0000,
        S_DIVR   = 13'b0_0000_0100_0000,
        S_SAT    = 13'b0_0000_1000_0000,
        S_SQN    = 13'b0_0001_0000_0000,
        S_SQE    = 13'b0_0010_0000_0000,
        S_SQRT   = 13'b0_0100_0000_0000,
        S_SQFIN  = 13'b0_1000_0000_0000,
        S_BEAR   = 13'b1_0000_0000_0000
    } t_state;

    t_state r_state;
    logic   r_wait_out;

    // configuration and tracking state
    logic               r_armed;
    logic               r_alarm_en;
    logic [7:0]         r_radius;
    logic [30:0]        r_anc_lat;
    logic [31:0]        r_anc_lon;
    logic [16:0]        r_cos;
    logic [31:0]        r_last_time;
    logic [23:0]        r_max_dist;

    // per-word working registers
    logic [31:0]        r_alat;
    logic [31:0]        r_alon;
    logic               r_lat_neg;
    logic               r_lon_neg;
    logic               r_valid;
    logic               r_sampled;
    logic [31:0]        r_now;
    logic [60:0]        r_prod;
    logic [47:0]        r_div_d;
    logic [13:0]        r_div_rem;
    logic [47:0]        r_div_q;
    logic [15:0]        r_qest;
    logic [4:0]         r_cnt;
    logic               r_east_sel;
    logic signed [23:0] r_north;
    logic signed [23:0] r_east;
    logic [47:0]        r_sq;
    logic [47:0]        r_root;
    logic [23:0]        r_dist;
    logic               r_bear_start;

    // output register
    logic               r_out_valid;
    logic signed [23:0] r_o_north;
    logic signed [23:0] r_o_east;
    logic [23:0]        r_o_dist;
    logic [8:0]         r_o_bear;
    logic               r_o_valid_pos;
    logic               r_o_alarm;
    logic [1:0]         r_o_status;
    logic               r_o_sampled;
    logic [23:0]        r_o_max;

    logic               in_acc;
    logic               out_free;
    logic               bear_done;
    logic [8:0]         bear_deg;
    logic signed [31:0] dlat;
    logic signed [32:0] dlon;
    logic [43:0]        mul_a;
    logic [16:0]        mul_b;
    logic [60:0]        mul_p;
    logic signed [23:0] sq_op;
    logic signed [47:0] sq_p;
    logic [61:0]        div_num;
    logic [29:0]        div_v;
    logic [29:0]        div_rem_est;
    logic               div_fix;
    logic [15:0]        q_digit;
    logic [47:0]        sat_mag;
    logic [23:0]        sat_off;
    logic               sat_neg;
    logic [47:0]        sqrt_bit;
    logic [47:0]        sqrt_sum;
    logic               alarm;
    logic [23:0]        max_next;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_wait_out;
    assign out_free   = !r_out_valid || !i_out_stall;

    // coordinate differences
    assign dlat = $signed({i_fix_latitude[30], i_fix_latitude})
                - $signed({r_anc_lat[30], r_anc_lat});
    assign dlon = $signed({i_fix_longitude[31], i_fix_longitude})
                - $signed({r_anc_lon[31], r_anc_lon});

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MULN:  begin
                mul_a = {12'd0, r_alat};
                mul_b = DEG_TO_SIXTEENTH;
            end
            S_MULE1: begin
                mul_a = {12'd0, r_alon};
                mul_b = DEG_TO_SIXTEENTH;
            end
            S_DIVQ:  begin
                mul_a = {14'd0, div_v};
                mul_b = DIV_RECIP;
            end
            S_DIVR:  begin
                mul_a = {28'd0, r_qest};
                mul_b = 17'(NORTH_DEN);
            end
            default: begin
                mul_a = r_prod[43:0];
                mul_b = r_cos;
            end
        endcase
    end
    assign mul_p = 61'(mul_a * mul_b);

    // squaring multiplier
    assign sq_op = (r_state == S_SQE) ? r_east : r_north;
    assign sq_p  = sq_op * sq_op;

    // radix 2^16 divide by 15625: reciprocal estimate, then one correction
    assign div_num     = {1'b0, r_prod} + (r_east_sel ? EAST_HALF : NORTH_HALF);
    assign div_v       = {r_div_rem, r_div_d[47:32]};
    assign div_rem_est = div_v - mul_p[29:0];
    assign div_fix     = div_rem_est >= NORTH_DEN;
    assign q_digit     = r_qest + {15'd0, div_fix};

    // saturation of the quotient
    always_comb begin
        sat_neg = r_east_sel ? r_lon_neg : r_lat_neg;
        if (sat_neg) begin
            sat_mag = (r_div_q > 48'(OFF_NEG_MAX)) ? 48'(OFF_NEG_MAX) : r_div_q;
            sat_off = 24'(-sat_mag[23:0]);
        end else begin
            sat_mag = (r_div_q > 48'(OFF_POS_MAX)) ? 48'(OFF_POS_MAX) : r_div_q;
            sat_off = sat_mag[23:0];
        end
    end

    // square root step
    assign sqrt_bit = 48'(1) << {r_cnt, 1'b0};
    assign sqrt_sum = r_root + sqrt_bit;

    // result flags
    assign alarm    = r_valid && r_alarm_en && (r_dist > {12'd0, r_radius, 4'd0});
    assign max_next = (r_sampled && r_dist > r_max_dist) ? r_dist : r_max_dist;

    adm_bearing u_bearing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_bear_start),
        .i_north   (r_north),
        .i_east    (r_east),
        .o_done    (bear_done),
        .o_bearing (bear_deg)
    );

    // configuration registers and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_alarm_en  <= 1'b0;
            r_radius    <= 8'd40;
            r_anc_lat   <= '0;
            r_anc_lon   <= '0;
            r_cos       <= 17'd65536;
            r_last_time <= '0;
            r_max_dist  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ANCHOR_ARMED: r_armed    <= i_cfg_data[0];
                REG_ALARM_ENABLE: r_alarm_en <= i_cfg_data[0];
                REG_ALARM_RADIUS: r_radius   <= i_cfg_data[7:0];
                REG_ANCHOR_LAT: begin
                    r_anc_lat   <= i_cfg_data[30:0];
                    r_max_dist  <= '0;
                    r_last_time <= '0;
                end
                REG_ANCHOR_LON: begin
                    r_anc_lon   <= i_cfg_data;
                    r_max_dist  <= '0;
                    r_last_time <= '0;
                end
                REG_ANCHOR_COS:   r_cos      <= i_cfg_data[16:0];
                default: ;
            endcase
        end else if (r_wait_out && out_free && r_sampled) begin
            r_last_time <= r_now;
            r_max_dist  <= max_next;
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wait_out   <= 1'b0;
            r_bear_start <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_bear_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (r_wait_out) begin
                        if (out_free) begin
                            r_wait_out <= 1'b0;
                        end
                    end else if (in_acc) begin
                        r_alat    <= dlat[31] ? 32'(-dlat) : 32'(dlat);
                        r_alon    <= dlon[32] ? 32'(-dlon) : 32'(dlon);
                        r_lat_neg <= dlat[31];
                        r_lon_neg <= dlon[32];
                        r_now     <= i_time_ms;
                        r_valid   <= r_armed && i_fix_present
                                     && (i_fix_age_ms < 16'(FIX_TIMEOUT_MS));
                        r_sampled <= r_armed && i_fix_present
                                     && ((i_time_ms - r_last_time)
                                         >= 32'(SAMPLE_INTERVAL_MS));
                        r_state   <= S_MULN;
                    end
                end
                S_MULN: begin
                    r_prod     <= mul_p;
                    r_east_sel <= 1'b0;
                    r_state    <= S_DIVSET;
                end
                S_MULE1: begin
                    r_prod  <= mul_p;
                    r_state <= S_MULE2;
                end
                S_MULE2: begin
                    r_prod     <= mul_p;
                    r_east_sel <= 1'b1;
                    r_state    <= S_DIVSET;
                end
                S_DIVSET: begin
                    r_div_d   <= r_east_sel ? {2'b00, div_num[61:16]} : div_num[47:0];
                    r_div_rem <= '0;
                    r_div_q   <= '0;
                    r_cnt     <= '0;
                    r_state   <= S_DIVQ;
                end
                S_DIVQ: begin
                    r_qest  <= mul_p[45:30];
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    r_div_rem <= div_fix ? 14'(div_rem_est - NORTH_DEN) : div_rem_est[13:0];
                    r_div_q   <= {r_div_q[31:0], q_digit};
                    r_div_d   <= {r_div_d[31:0], 16'd0};
                    r_cnt     <= r_cnt + 5'd1;
                    if (r_cnt == 5'd2) begin
                        r_state <= S_SAT;
                    end else begin
                        r_state <= S_DIVQ;
                    end
                end
                S_SAT: begin
                    if (r_east_sel) begin
                        r_east  <= $signed(sat_off);
                        r_state <= S_SQN;
                    end else begin
                        r_north <= $signed(sat_off);
                        r_state <= S_MULE1;
                    end
                end
                S_SQN: begin
                    r_sq    <= 48'(sq_p);
                    r_state <= S_SQE;
                end
                S_SQE: begin
                    r_sq    <= r_sq + 48'(sq_p);
                    r_root  <= '0;
                    r_cnt   <= 5'd23;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sq >= sqrt_sum) begin
                        r_sq   <= r_sq - sqrt_sum;
                        r_root <= (r_root >> 1) + sqrt_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_cnt == 5'd0) begin
                        r_state <= S_SQFIN;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_SQFIN: begin
                    r_dist       <= (r_sq > r_root) ? 24'(r_root + 48'd1) : r_root[23:0];
                    r_bear_start <= 1'b1;
                    r_state      <= S_BEAR;
                end
                S_BEAR: begin
                    if (bear_done) begin
                        r_wait_out <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_wait_out && out_free) begin
            r_out_valid   <= 1'b1;
            r_o_north     <= r_valid ? r_north : '0;
            r_o_east      <= r_valid ? r_east : '0;
            r_o_dist      <= r_valid ? r_dist : '0;
            r_o_bear      <= r_valid ? bear_deg : '0;
            r_o_valid_pos <= r_valid;
            r_o_alarm     <= alarm;
            r_o_status    <= !r_armed ? STATUS_NOT_ARMED :
                             (!r_valid ? STATUS_NO_FIX :
                             (alarm ? STATUS_DRAGGING : STATUS_NO_MSG));
            r_o_sampled   <= r_sampled;
            r_o_max       <= max_next;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_north_offset   = r_o_north;
    assign o_east_offset    = r_o_east;
    assign o_distance       = r_o_dist;
    assign o_bearing_deg    = r_o_bear;
    assign o_position_valid = r_o_valid_pos;
    assign o_drag_alarm     = r_o_alarm;
    assign o_status         = r_o_status;
    assign o_track_sampled  = r_o_sampled;
    assign o_max_drift      = r_o_max;

endmodule

### hw/rtl/adm_bearing.sv
// adm_bearing: iterative cordic vectoring unit giving the bearing in whole degrees
// depends on adm_pkg
module adm_bearing (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [adm_pkg::OFF_W-1:0]  i_north,
    input  logic signed [adm_pkg::OFF_W-1:0]  i_east,
    output logic                              o_done,
    output logic [8:0]                        o_bearing
);
    import adm_pkg::*;

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [4:0]         r_step;
    logic signed [34:0] r_x;
    logic signed [34:0] r_y;
    logic signed [24:0] r_z;
    logic               r_n_neg;
    logic               r_e_neg;
    logic [8:0]         r_bear;

    logic [23:0]        n_mag;
    logic [23:0]        e_mag;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic [34:0]        y_mag;
    logic [34:0]        y_sh;
    logic signed [24:0] ang;
    logic signed [26:0] t_raw;
    logic signed [26:0] t_wrap;
    logic [26:0]        t_rnd;
    logic [8:0]         deg;

    // operand magnitudes
    assign n_mag = i_north[OFF_W-1] ? 24'(-i_north) : 24'(i_north);
    assign e_mag = i_east[OFF_W-1]  ? 24'(-i_east)  : 24'(i_east);

    // shifts rounded toward zero
    assign y_mag = r_y[34] ? 35'(-r_y) : 35'(r_y);
    assign y_sh  = y_mag >> r_step;
    assign dx    = r_y[34] ? -$signed(y_sh) : $signed(y_sh);
    assign dy    = r_x >>> r_step;
    assign ang   = $signed({2'b00, adm_atan(r_step)});

    // quadrant correction and rounding
    always_comb begin
        if (!r_n_neg && !r_e_neg) begin
            t_raw = 27'(r_z);
        end else if (r_n_neg && !r_e_neg) begin
            t_raw = DEG180_Q16 - 27'(r_z);
        end else if (r_n_neg) begin
            t_raw = DEG180_Q16 + 27'(r_z);
        end else begin
            t_raw = DEG360_Q16 - 27'(r_z);
        end
        if (t_raw < 0) begin
            t_wrap = t_raw + DEG360_Q16;
        end else if (t_raw >= DEG360_Q16) begin
            t_wrap = t_raw - DEG360_Q16;
        end else begin
            t_wrap = t_raw;
        end
        t_rnd = 27'(t_wrap + HALF_DEG_Q16) >> 16;
        deg   = (t_rnd[8:0] == 9'd360) ? 9'd0 : t_rnd[8:0];
    end

    // rotation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_x     <= $signed({3'b000, n_mag, 8'd0});
                r_y     <= $signed({3'b000, e_mag, 8'd0});
                r_z     <= '0;
                r_n_neg <= i_north[OFF_W-1];
                r_e_neg <= i_east[OFF_W-1];
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end else if (r_y < 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_bear <= deg;
            end
        end
    end

    assign o_done    = r_done;
    assign o_bearing = r_bear;

endmodule
